// File: sv/sfd_crc_pkg.sv
// ----------------------------------------------------------------------------
// sfd_crc_pkg
// Frame layout constants and the byte-wide CRC-16/CCITT-FALSE update used by
// the speed frame deframer.
// ----------------------------------------------------------------------------
package sfd_crc_pkg;

    // Frame marker, used as both the start byte and the end byte.
    localparam logic [7:0]  FRAME_MARK   = 8'h7E;

    // Byte positions within the 31-byte frame.
    localparam int          POS_W        = 5;
    localparam logic [4:0]  POS_START    = 5'd0;
    localparam logic [4:0]  POS_FIRST    = 5'd1;
    localparam logic [4:0]  POS_SPEED_HI = 5'd6;
    localparam logic [4:0]  POS_SPEED_LO = 5'd7;
    localparam logic [4:0]  POS_CRC_LAST = 5'd27;
    localparam logic [4:0]  POS_CRC_HI   = 5'd28;
    localparam logic [4:0]  POS_CRC_LO   = 5'd29;
    localparam logic [4:0]  POS_END      = 5'd30;

    // CRC-16/CCITT-FALSE: MSB first, no reflection, no final xor.
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'h1021;

    // Feed one byte into the running CRC, one bit per loop step.
    function automatic logic [15:0] crc16_feed(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end
            else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

// File: sv/speed_frame_deframer_crc16_unit.sv
// ----------------------------------------------------------------------------
// speed_frame_deframer_crc16_unit
// Assembles received serial bytes into 31-byte speed frames and checks them.
// ----------------------------------------------------------------------------
// Usage:
// Bytes enter on the input channel (in_valid, in_stall, rx_byte), one beat
// per byte. A frame opens with 0x7E; junk before it is dropped, and a second
// 0x7E right after the start restarts the frame. Bytes 1 to 27 feed a
// CRC-16/CCITT-FALSE, bytes 6 and 7 carry the speed, bytes 28 and 29 the
// CRC, and byte 30 must be 0x7E.
// One result beat (frame_ok, speed_kmh) leaves on the output channel
// (out_valid, out_stall) for each frame, in the cycle after byte 30 is taken.
// speed_kmh reads 0 when frame_ok is 0.
// Throughput is one byte per cycle: the byte-wide CRC update and the
// position counter sit between the state registers and the result register.
// While a result waits under out_stall, bytes keep being taken; only the
// end byte of the next frame is held off until the result leaves.
// Reset clears the byte position, reloads the CRC and empties the result
// register.
// ----------------------------------------------------------------------------
module speed_frame_deframer_crc16_unit
    import sfd_crc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        frame_ok,
    output logic [15:0] speed_kmh
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [15:0]      crc_reg;
    logic [15:0]      crc_next;
    logic [15:0]      speed_reg;
    logic [15:0]      speed_next;
    logic [15:0]      rx_crc_reg;
    logic [15:0]      rx_crc_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             frame_ok_reg;
    logic             frame_ok_next;
    logic [15:0]      speed_kmh_reg;
    logic [15:0]      speed_kmh_next;

    logic             in_accept;
    logic             out_accept;
    logic             emit;
    logic             is_mark;
    logic             restart;
    logic [POS_W-1:0] pos_eff;

    // Handshake: hold off only an end byte while a result is still waiting.
    assign in_stall   = out_valid_reg && out_stall && (pos_reg == POS_END);
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;

    // Frame parsing and CRC update for the byte on the input.
    always_comb
    begin
        pos_eff     = (pos_reg > POS_END) ? POS_START : pos_reg;
        is_mark     = (rx_byte == FRAME_MARK);
        restart     = (pos_eff == POS_START) || ((pos_eff == POS_FIRST) && is_mark);
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        speed_next  = speed_reg;
        rx_crc_next = rx_crc_reg;
        emit        = 1'b0;

        if (in_accept) begin
            if (restart) begin
                if (is_mark) begin
                    crc_next = CRC_INIT;
                    pos_next = POS_FIRST;
                end
                else begin
                    pos_next = pos_eff;
                end
            end
            else begin
                if (pos_eff <= POS_CRC_LAST) begin
                    crc_next = crc16_feed(crc_reg, rx_byte);
                end
                case (pos_eff)
                    POS_SPEED_HI: speed_next  = {rx_byte, speed_reg[7:0]};
                    POS_SPEED_LO: speed_next  = {speed_reg[15:8], rx_byte};
                    POS_CRC_HI:   rx_crc_next = {rx_byte, rx_crc_reg[7:0]};
                    POS_CRC_LO:   rx_crc_next = {rx_crc_reg[15:8], rx_byte};
                    default:      ;
                endcase
                if (pos_eff == POS_END) begin
                    emit     = 1'b1;
                    pos_next = POS_START;
                end
                else begin
                    pos_next = pos_eff + POS_W'(1);
                end
            end
        end
    end

    // Result register: loads on a frame end, clears when the beat is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        frame_ok_next  = frame_ok_reg;
        speed_kmh_next = speed_kmh_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            frame_ok_next  = is_mark && (rx_crc_reg == crc_reg);
            speed_kmh_next = (is_mark && (rx_crc_reg == crc_reg)) ? speed_reg : 16'h0000;
        end
        else if (out_accept) begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg       <= POS_START;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        speed_reg     <= speed_next;
        rx_crc_reg    <= rx_crc_next;
        frame_ok_reg  <= frame_ok_next;
        speed_kmh_reg <= speed_kmh_next;
    end

    assign out_valid = out_valid_reg;
    assign frame_ok  = frame_ok_reg;
    assign speed_kmh = speed_kmh_reg;

    // Checks on the parser and result logic.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_END)
        else $error("byte position out of frame range");

    a_bad_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !frame_ok) |-> (speed_kmh == 16'h0000))
        else $error("rejected frame carries a nonzero speed");

    a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (pos_reg == POS_END)) |=> (out_valid && (pos_reg == POS_START)))
        else $error("end byte did not produce a result");

    a_junk_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (pos_reg == POS_START) && (rx_byte != FRAME_MARK))
        |=> (pos_reg == POS_START))
        else $error("junk byte moved the frame position");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a waiting result");

endmodule
